>>> design/suss_pkg.sv
// Shared constants for the sorted unique set store: command and status codes, sizes.
`default_nettype none
package suss_pkg;

  // Default number of entries the store can hold
  localparam int CAPACITY_DEF = 32;

  // Word field widths
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int VALUE_W  = 32;

  // Commands
  localparam logic [CMD_W-1:0] CMD_INSERT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SHOW_ASC  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SHOW_DESC = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd5;

endpackage
`default_nettype wire

>>> design/sorted_unique_set_store.sv
// Sorted unique set store: ascending list of signed values held in one on-chip memory.
//
// Input words (command, value) arrive on in_valid/in_stall; result words
// (status, listed_value, empty_list, last_result) leave on out_valid/out_stall.
// One command is worked at a time; in_stall is high from acceptance until the
// command's last result word has been loaded into the output register.
// Steps from acceptance to loading the last result word:
//   insert: search and shift visit each entry about once, plus a stop read,
//           the value write and the response
//   delete: search then shift down
//   show:   a registered read of the first entry, then one result word per
//           cycle while the output is not stalled (one word when empty)
// The walks are paced by the single memory read port, one entry per cycle
// unless a show walk waits on the output, with the read data registered.
// The output register lets the next command be accepted while the final
// result word still waits to be taken.
// A stalled receiver holds the output word; a show walk pauses until the
// word is taken. Reset empties the store (entry count zero) and clears
// out_valid; memory contents are not cleared and only written entries are read.
`default_nettype none
module sorted_unique_set_store
  import suss_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [CMD_W-1:0]           command,
  input  wire logic signed [VALUE_W-1:0]  value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [STATUS_W-1:0]             status,
  output logic signed [VALUE_W-1:0]       listed_value,
  output logic                            empty_list,
  output logic                            last_result
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_ISH  = 3'd2;
  localparam logic [2:0] S_IPUT = 3'd3;
  localparam logic [2:0] S_DSH  = 3'd4;
  localparam logic [2:0] S_SHOW = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;

  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rd_data;

  logic [2:0]           state, state_next;
  logic [CW-1:0]        ptr, ptr_next;
  logic [CW-1:0]        cnt, cnt_next;
  logic [CMD_W-1:0]     cmd_r, cmd_next;
  logic [VALUE_W-1:0]   val_r, val_next;
  logic [STATUS_W-1:0]  resp_status, resp_status_next;
  logic                 resp_empty, resp_empty_next;
  logic                 out_valid_next;
  logic [STATUS_W-1:0]  status_next;
  logic [VALUE_W-1:0]   listed_next;
  logic                 empty_next;
  logic                 last_next;

  logic                 rd_en;
  logic [CW-1:0]        rd_idx;
  logic                 wr_en;
  logic [CW-1:0]        wr_idx;
  logic [VALUE_W-1:0]   wr_data;

  logic                 out_free;
  logic                 key_ge;
  logic                 key_eq;
  logic [CW-1:0]        cnt_last;
  logic                 show_last;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign key_ge   = $signed(rd_data) >= $signed(val_r);
  assign key_eq   = rd_data == val_r;
  assign cnt_last = cnt - ONE_C;
  assign show_last = (cmd_r == CMD_SHOW_ASC) ? (ptr == cnt_last) : (ptr == '0);

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx[AW-1:0]];
    end
  end

  // Command sequencer
  always_comb begin
    state_next       = state;
    ptr_next         = ptr;
    cnt_next         = cnt;
    cmd_next         = cmd_r;
    val_next         = val_r;
    resp_status_next = resp_status;
    resp_empty_next  = resp_empty;
    out_valid_next   = out_valid && out_stall;
    status_next      = status;
    listed_next      = listed_value;
    empty_next       = empty_list;
    last_next        = last_result;
    rd_en            = 1'b0;
    rd_idx           = ptr;
    wr_en            = 1'b0;
    wr_idx           = ptr;
    wr_data          = rd_data;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_next        = command;
          val_next        = value;
          resp_empty_next = 1'b0;
          ptr_next        = '0;
          if (command == CMD_INSERT || command == CMD_DELETE) begin
            if (cnt == '0) begin
              if (command == CMD_INSERT) begin
                state_next = S_IPUT;
              end else begin
                resp_status_next = ST_NOT_FOUND;
                state_next       = S_RESP;
              end
            end else begin
              rd_en      = 1'b1;
              rd_idx     = '0;
              state_next = S_SRCH;
            end
          end else begin
            if (cnt == '0) begin
              resp_status_next = ST_LISTED;
              resp_empty_next  = 1'b1;
              state_next       = S_RESP;
            end else begin
              ptr_next   = (command == CMD_SHOW_ASC) ? '0 : cnt_last;
              rd_en      = 1'b1;
              rd_idx     = ptr_next;
              state_next = S_SHOW;
            end
          end
        end
      end

      // Walk up from entry 0; rd_data holds entry ptr
      S_SRCH: begin
        if (cmd_r == CMD_INSERT) begin
          if (key_ge && key_eq) begin
            resp_status_next = ST_DUPLICATE;
            state_next       = S_RESP;
          end else if (key_ge || ptr == cnt_last) begin
            if (cnt == CAP_C) begin
              resp_status_next = ST_FULL;
              state_next       = S_RESP;
            end else if (!key_ge) begin
              // new largest value goes at the end
              ptr_next   = cnt;
              state_next = S_IPUT;
            end else begin
              // shift entries ptr..cnt-1 up by one, top first
              ptr_next   = cnt_last;
              rd_en      = 1'b1;
              rd_idx     = cnt_last;
              state_next = S_ISH;
            end
          end else begin
            ptr_next = ptr + ONE_C;
            rd_en    = 1'b1;
            rd_idx   = ptr_next;
          end
        end else begin
          if (key_eq) begin
            if (ptr == cnt_last) begin
              cnt_next         = cnt_last;
              resp_status_next = ST_DELETED;
              state_next       = S_RESP;
            end else begin
              ptr_next   = ptr + ONE_C;
              rd_en      = 1'b1;
              rd_idx     = ptr_next;
              state_next = S_DSH;
            end
          end else if (ptr == cnt_last) begin
            resp_status_next = ST_NOT_FOUND;
            state_next       = S_RESP;
          end else begin
            ptr_next = ptr + ONE_C;
            rd_en    = 1'b1;
            rd_idx   = ptr_next;
          end
        end
      end

      // Insert shift: a larger entry ptr moves to ptr+1; a smaller one
      // marks the insert slot just above it
      S_ISH: begin
        if ($signed(rd_data) > $signed(val_r)) begin
          wr_en  = 1'b1;
          wr_idx = ptr + ONE_C;
          if (ptr != '0) begin
            ptr_next = ptr - ONE_C;
            rd_en    = 1'b1;
            rd_idx   = ptr_next;
          end else begin
            state_next = S_IPUT;
          end
        end else begin
          ptr_next   = ptr + ONE_C;
          state_next = S_IPUT;
        end
      end

      // Place the new value at slot ptr
      S_IPUT: begin
        wr_en            = 1'b1;
        wr_idx           = ptr;
        wr_data          = val_r;
        cnt_next         = cnt + ONE_C;
        resp_status_next = ST_INSERTED;
        state_next       = S_RESP;
      end

      // Delete shift: entry ptr moves to ptr-1
      S_DSH: begin
        wr_en  = 1'b1;
        wr_idx = ptr - ONE_C;
        if (ptr == cnt_last) begin
          cnt_next         = cnt_last;
          resp_status_next = ST_DELETED;
          state_next       = S_RESP;
        end else begin
          ptr_next = ptr + ONE_C;
          rd_en    = 1'b1;
          rd_idx   = ptr_next;
        end
      end

      // Listing: rd_data holds entry ptr; wait for a free output slot
      S_SHOW: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          status_next    = ST_LISTED;
          listed_next    = rd_data;
          empty_next     = 1'b0;
          last_next      = show_last;
          if (show_last) begin
            state_next = S_IDLE;
          end else begin
            ptr_next = (cmd_r == CMD_SHOW_ASC) ? ptr + ONE_C : ptr - ONE_C;
            rd_en    = 1'b1;
            rd_idx   = ptr_next;
          end
        end
      end

      // Single result word for insert, delete or empty listing
      S_RESP: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          status_next    = resp_status;
          listed_next    = '0;
          empty_next     = resp_empty;
          last_next      = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ptr          <= ptr_next;
    cmd_r        <= cmd_next;
    val_r        <= val_next;
    resp_status  <= resp_status_next;
    resp_empty   <= resp_empty_next;
    status       <= status_next;
    listed_value <= listed_next;
    empty_list   <= empty_next;
    last_result  <= last_next;
  end

endmodule
`default_nettype wire
